>>> sv/fcgm_pkg.sv
// Shared types and constants for the font codepoint-to-glyph map.
// No dependencies; used by the byte decoder and the top level.
package fcgm_pkg;

	localparam int unsigned CP_W    = 21;
	localparam int unsigned GLYPH_W = 16;

	typedef enum logic [1:0] {
		KIND_BYTE   = 2'd0,
		KIND_LOOKUP = 2'd1,
		KIND_CLEAR  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_STORE_A,
		ST_STORE_B
	} state_t;

	localparam logic [0:0] REG_GLYPH_COUNT     = 1'd0;
	localparam logic [0:0] REG_UNICODE_ENABLED = 1'd1;

	localparam logic [7:0]      BYTE_END_GLYPH = 8'hFF;
	localparam logic [7:0]      BYTE_SKIP      = 8'hFE;
	localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;
	localparam logic [CP_W-1:0] CP_PLANE_LIMIT = 21'h010000;

	// Decoder state that rides along with each table byte
	typedef struct packed {
		logic [1:0]      pend;
		logic [CP_W-1:0] point;
		logic [GLYPH_W-1:0] glyph;
	} dec_state_t;

	// Result of decoding one table byte: up to two map stores and the next state
	typedef struct packed {
		logic            st_a;
		logic [CP_W-1:0] cp_a;
		logic            st_b;
		logic [CP_W-1:0] cp_b;
		logic            closed;
		dec_state_t      nxt;
	} dec_out_t;

endpackage

>>> sv/fcgm_map_ram.sv
// Glyph map storage: one write port, one read port, registered read data.
// No package dependencies; instantiated by the top level.
module fcgm_map_ram #(
	parameter int unsigned DEPTH = 65536,
	parameter int unsigned AW    = 16,
	parameter int unsigned DW    = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/fcgm_utf8_step.sv
// UTF-8 table byte decoder: one byte against the current decoder state.
// Depends on fcgm_pkg; instantiated by the top level.
module fcgm_utf8_step (
	input  logic [7:0]                    table_byte,
	input  logic                          end_of_table,
	input  logic [fcgm_pkg::GLYPH_W-1:0]  glyph_count,
	input  fcgm_pkg::dec_state_t          cur,
	output fcgm_pkg::dec_out_t            res
);
	import fcgm_pkg::*;

	logic            lead;
	logic [CP_W-1:0] cat;

	assign cat = {cur.point[CP_W-7:0], table_byte[5:0]};

	always_comb begin
		res      = '0;
		res.nxt  = cur;
		lead     = 1'b1;
		if (cur.pend != 2'd0) begin
			if (table_byte[7:6] == 2'b10) begin
				lead         = 1'b0;
				res.nxt.pend = cur.pend - 2'd1;
				if (cur.pend == 2'd1) begin
					res.st_a      = 1'b1;
					res.cp_a      = cat;
					res.nxt.point = '0;
				end else begin
					res.nxt.point = cat;
				end
			end else begin
				res.st_a      = 1'b1;
				res.cp_a      = CP_REPLACEMENT;
				res.nxt.pend  = 2'd0;
				res.nxt.point = '0;
			end
		end
		if (lead && (cur.glyph < glyph_count)) begin
			if (table_byte == BYTE_END_GLYPH) begin
				res.nxt.glyph = cur.glyph + 16'd1;
			end else if (table_byte == BYTE_SKIP) begin
				res.st_b = 1'b0;
			end else if (table_byte[7] == 1'b0) begin
				res.st_b = 1'b1;
				res.cp_b = {13'd0, table_byte};
			end else if (table_byte[7:5] == 3'b110) begin
				res.nxt.point = {16'd0, table_byte[4:0]};
				res.nxt.pend  = 2'd1;
			end else if (table_byte[7:4] == 4'b1110) begin
				res.nxt.point = {17'd0, table_byte[3:0]};
				res.nxt.pend  = 2'd2;
			end else if (table_byte[7:3] == 5'b11110) begin
				res.nxt.point = {18'd0, table_byte[2:0]};
				res.nxt.pend  = 2'd3;
			end else begin
				res.st_b = 1'b1;
				res.cp_b = CP_REPLACEMENT;
			end
		end
		if (end_of_table) begin
			res.nxt.pend  = 2'd0;
			res.nxt.point = '0;
			res.closed    = 1'b1;
		end
	end

endmodule

>>> sv/font_codepoint_glyph_map.sv
// Top level of the font codepoint-to-glyph map: control, registers, lookup.
// Depends on fcgm_pkg, fcgm_utf8_step and fcgm_map_ram.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------------------------
//   in       | in_valid / in_ready    | kind, table_byte, end_of_table, query_point
//   out      | out_valid / out_ready  | glyph_number
//   cfg      | cfg_we (no wait)       | cfg_index, cfg_wdata
//
// A lookup reads the map when it is accepted, then moves the result into the output register.
// A table byte is accepted, then passes through one store state for each map store it causes
// (the read goes out with the accept or with the previous write); at most two stores per byte.
// After reset and after a clear item the map is zeroed one entry a cycle,
// through all MAP_ENTRIES entries, with in_ready low; config writes are taken meanwhile.
// A lookup waits at the input while a previous result is not yet taken.
module font_codepoint_glyph_map #(
	parameter int unsigned MAP_ENTRIES = 65536
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    kind,
	input  logic [7:0]                    table_byte,
	input  logic                          end_of_table,
	input  logic [fcgm_pkg::CP_W-1:0]     query_point,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [fcgm_pkg::GLYPH_W-1:0]  glyph_number,
	input  logic                          cfg_we,
	input  logic [0:0]                    cfg_index,
	input  logic [fcgm_pkg::GLYPH_W-1:0]  cfg_wdata
);
	import fcgm_pkg::*;

	localparam int unsigned AW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_ENTRIES - 1);

	state_t state_q, state_d;

	logic [GLYPH_W-1:0] glyph_count_q;
	logic               unicode_q;
	dec_state_t         dec_q;
	logic               closed_q;
	logic [AW-1:0]      clr_addr_q;
	logic               out_valid_q;
	logic [GLYPH_W-1:0] glyph_number_q;

	logic [AW-1:0]      addr_a_s1, addr_b_s1;
	logic               st_b_s1;
	logic               a_wrote_s1;
	logic [GLYPH_W-1:0] glyph_s1;
	logic [CP_W-1:0]    q_s1;
	logic               q_in_map_s1;
	logic               unicode_s1;

	dec_out_t  dec;
	logic      accept;
	logic      is_byte, is_lookup, is_clear;
	logic      ok_a, ok_b, q_in_map;
	logic      ram_we, ram_re;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	logic [GLYPH_W-1:0] ram_wdata, ram_rdata;
	logic [GLYPH_W-1:0] look_g, fallback, look_res;

	function automatic logic in_range(input logic [CP_W-1:0] cp);
		in_range = (cp < CP_PLANE_LIMIT) && ({11'd0, cp} < 32'(MAP_ENTRIES));
	endfunction

	fcgm_utf8_step u_step (
		.table_byte   (table_byte),
		.end_of_table (end_of_table),
		.glyph_count  (glyph_count_q),
		.cur          (dec_q),
		.res          (dec)
	);

	fcgm_map_ram #(
		.DEPTH (MAP_ENTRIES),
		.AW    (AW),
		.DW    (GLYPH_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign is_byte   = (kind == KIND_BYTE);
	assign is_lookup = (kind == KIND_LOOKUP);
	assign is_clear  = (kind == KIND_CLEAR);

	assign in_ready = (state_q == ST_IDLE) && (!is_lookup || !out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;

	assign ok_a     = !closed_q && dec.st_a && in_range(dec.cp_a);
	assign ok_b     = !closed_q && dec.st_b && in_range(dec.cp_b);
	assign q_in_map = unicode_q && in_range(query_point);

	assign fallback = ({11'd0, q_s1} < {16'd0, glyph_count_q}) ? q_s1[GLYPH_W-1:0] : '0;
	assign look_g   = q_in_map_s1 ? ram_rdata : '0;

	always_comb begin
		if (!unicode_s1) begin
			look_res = fallback;
		end else if (q_s1 >= CP_PLANE_LIMIT) begin
			look_res = '0;
		end else if ((look_g != '0) || (q_s1 == '0)) begin
			look_res = look_g;
		end else begin
			look_res = fallback;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = addr_a_s1;
		ram_wdata = glyph_s1;
		ram_re    = 1'b0;
		ram_raddr = ok_a ? dec.cp_a[AW-1:0] : dec.cp_b[AW-1:0];
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_addr_q;
				ram_wdata = '0;
				if (clr_addr_q == LAST_ADDR) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (is_lookup) begin
						ram_re    = q_in_map;
						ram_raddr = query_point[AW-1:0];
						state_d   = ST_LOOK;
					end else if (is_clear) begin
						state_d = ST_CLEAR;
					end else if (is_byte && ok_a) begin
						ram_re  = 1'b1;
						state_d = ST_STORE_A;
					end else if (is_byte && ok_b) begin
						ram_re  = 1'b1;
						state_d = ST_STORE_B;
					end
				end
			end
			ST_LOOK: begin
				state_d = ST_IDLE;
			end
			ST_STORE_A: begin
				ram_we    = (ram_rdata == '0);
				ram_waddr = addr_a_s1;
				if (st_b_s1) begin
					ram_re    = 1'b1;
					ram_raddr = addr_b_s1;
					state_d   = ST_STORE_B;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_STORE_B: begin
				// entry just written by the first store reads stale here
				ram_we    = (ram_rdata == '0) && !(a_wrote_s1 && (addr_a_s1 == addr_b_s1));
				ram_waddr = addr_b_s1;
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glyph_count_q <= 16'd256;
			unicode_q     <= 1'b1;
		end else if (cfg_we) begin
			if (cfg_index == REG_GLYPH_COUNT) begin
				glyph_count_q <= cfg_wdata;
			end else if (cfg_index == REG_UNICODE_ENABLED) begin
				unicode_q <= cfg_wdata[0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_q      <= '0;
			closed_q   <= 1'b0;
			clr_addr_q <= '0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (accept && is_clear) begin
				dec_q      <= '0;
				closed_q   <= 1'b0;
				clr_addr_q <= '0;
			end else if (accept && is_byte && !closed_q) begin
				dec_q    <= dec.nxt;
				closed_q <= dec.closed;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_a_s1   <= dec.cp_a[AW-1:0];
			addr_b_s1   <= dec.cp_b[AW-1:0];
			st_b_s1     <= ok_a && ok_b;
			glyph_s1    <= dec_q.glyph;
			q_s1        <= query_point;
			q_in_map_s1 <= q_in_map;
			unicode_s1  <= unicode_q;
			a_wrote_s1  <= 1'b0;
		end else if (state_q == ST_STORE_A) begin
			a_wrote_s1 <= ram_we;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_LOOK) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOOK) begin
			glyph_number_q <= look_res;
		end
	end

	assign out_valid    = out_valid_q;
	assign glyph_number = glyph_number_q;

endmodule

>>> test/font_codepoint_glyph_map_test.sv
// Self-checking testbench for font_codepoint_glyph_map: UTF-8 table loading,
// glyph limits, lookups with map and direct indexing. Depends on fcgm_pkg and
// the RTL; a behavioral image of the glyph map predicts every lookup result.
module font_codepoint_glyph_map_test;
	timeunit 1ns;
	timeprecision 1ps;

	import fcgm_pkg::*;

	localparam int unsigned MAP_ENTRIES = 65536;
	localparam logic [1:0]  KIND_UNUSED = 2'd3;
	localparam int          CYCLE_LIMIT = 3_000_000;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [1:0]           kind;
	logic [7:0]           table_byte;
	logic                 end_of_table;
	logic [CP_W-1:0]      query_point;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [GLYPH_W-1:0]   glyph_number;
	logic                 cfg_we;
	logic [0:0]           cfg_index;
	logic [GLYPH_W-1:0]   cfg_wdata;

	// glyph map image: a missing entry reads as zero
	bit [GLYPH_W-1:0] map_image [int];
	bit [GLYPH_W-1:0] load_glyph;
	bit [CP_W-1:0]    partial_cp;
	bit [1:0]         cont_left;
	bit               table_done;
	bit [GLYPH_W-1:0] glyph_limit;
	bit               map_on;

	bit [GLYPH_W-1:0] pending_glyphs [$];
	bit [7:0]         byte_plan [$];
	bit [CP_W-1:0]    known_points [$];

	bit steady = 1'b0;
	int mismatch_count = 0;
	int live_items = 0;
	int cycle_count = 0;

	font_codepoint_glyph_map #(
		.MAP_ENTRIES(MAP_ENTRIES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.table_byte(table_byte),
		.end_of_table(end_of_table),
		.query_point(query_point),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.glyph_number(glyph_number),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic bit [GLYPH_W-1:0] map_entry(bit [CP_W-1:0] cp);
		if (map_image.exists(int'(cp)))
			return map_image[int'(cp)];
		return '0;
	endfunction

	function automatic void store_point(bit [CP_W-1:0] cp);
		if (cp < CP_PLANE_LIMIT && cp < MAP_ENTRIES && map_entry(cp) == 0)
			map_image[int'(cp)] = load_glyph;
	endfunction

	function automatic void start_point(bit [7:0] b);
		if (load_glyph >= glyph_limit)
			return;
		if (b == BYTE_END_GLYPH) begin
			load_glyph = load_glyph + 16'd1;
		end else if (b == BYTE_SKIP) begin
			return;
		end else if (b[7] == 1'b0) begin
			store_point({13'd0, b});
		end else if (b[7:5] == 3'b110) begin
			partial_cp = {16'd0, b[4:0]};
			cont_left = 2'd1;
		end else if (b[7:4] == 4'b1110) begin
			partial_cp = {17'd0, b[3:0]};
			cont_left = 2'd2;
		end else if (b[7:3] == 5'b11110) begin
			partial_cp = {18'd0, b[2:0]};
			cont_left = 2'd3;
		end else begin
			store_point(CP_REPLACEMENT);
		end
	endfunction

	function automatic void load_table_byte(bit [7:0] b, bit last);
		if (table_done)
			return;
		if (cont_left != 0) begin
			if (b[7:6] == 2'b10) begin
				partial_cp = {partial_cp[CP_W-7:0], b[5:0]};
				cont_left = cont_left - 2'd1;
				if (cont_left == 0) begin
					store_point(partial_cp);
					partial_cp = '0;
				end
			end else begin
				store_point(CP_REPLACEMENT);
				cont_left = '0;
				partial_cp = '0;
				start_point(b);
			end
		end else begin
			start_point(b);
		end
		if (last) begin
			cont_left = '0;
			partial_cp = '0;
			table_done = 1'b1;
		end
	endfunction

	function automatic void clear_image();
		map_image.delete();
		load_glyph = '0;
		partial_cp = '0;
		cont_left = '0;
		table_done = 1'b0;
	endfunction

	function automatic bit [GLYPH_W-1:0] lookup_glyph(bit [CP_W-1:0] cp);
		bit [GLYPH_W-1:0] g;
		g = '0;
		if (map_on) begin
			if (cp >= CP_PLANE_LIMIT)
				return '0;
			if (cp < MAP_ENTRIES)
				g = map_entry(cp);
			if (g != 0 || cp == 0)
				return g;
		end
		if (cp < glyph_limit)
			return cp[GLYPH_W-1:0];
		return '0;
	endfunction

	function automatic void apply_item(logic [1:0] k, logic [7:0] b, logic e,
			logic [CP_W-1:0] q);
		if (k == KIND_BYTE)
			load_table_byte(b, e);
		else if (k == KIND_LOOKUP)
			pending_glyphs.push_back(lookup_glyph(q));
		else if (k == KIND_CLEAR)
			clear_image();
	endfunction

	task automatic report_mismatch(input string what);
		$display("ERROR at %0t: %s", $realtime, what);
		mismatch_count++;
	endtask

	task automatic send_item(input logic [1:0] k, input logic [7:0] b, input logic e,
			input logic [CP_W-1:0] q);
		while (!steady && $urandom_range(99) < 38) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		if (!((k == KIND_BYTE && table_done) || k == KIND_UNUSED))
			live_items++;
		in_valid <= 1'b1;
		kind <= k;
		table_byte <= b;
		end_of_table <= e;
		query_point <= q;
		do @(posedge clk); while (!in_ready);
		apply_item(k, b, e, q);
	endtask

	task automatic send_table_byte(input bit [7:0] b, input bit last);
		send_item(KIND_BYTE, b, last, CP_W'($urandom_range(0, 21'h1FFFFF)));
	endtask

	task automatic send_lookup(input bit [CP_W-1:0] cp);
		send_item(KIND_LOOKUP, 8'($urandom_range(255)), 1'($urandom_range(1)), cp);
	endtask

	task automatic send_clear();
		send_item(KIND_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)),
			CP_W'($urandom_range(0, 21'h1FFFFF)));
	endtask

	// drop valid, drain results, wait out a clearing pass, then cover a table byte
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_glyphs.size() != 0)
			@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [GLYPH_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_GLYPH_COUNT)
			glyph_limit = val;
		else
			map_on = val[0];
		@(posedge clk);
	endtask

	function automatic void encode_point(bit [CP_W-1:0] cp);
		int len;
		if (cp < 21'h80)
			len = 1;
		else if (cp < 21'h800)
			len = 2;
		else if (cp < CP_PLANE_LIMIT)
			len = 3;
		else
			len = 4;
		if (len < 4 && $urandom_range(99) < 8)
			len++;
		case (len)
			1: byte_plan.push_back({1'b0, cp[6:0]});
			2: begin
				byte_plan.push_back({3'b110, cp[10:6]});
				byte_plan.push_back({2'b10, cp[5:0]});
			end
			3: begin
				byte_plan.push_back({4'b1110, cp[15:12]});
				byte_plan.push_back({2'b10, cp[11:6]});
				byte_plan.push_back({2'b10, cp[5:0]});
			end
			default: begin
				byte_plan.push_back({5'b11110, cp[20:18]});
				byte_plan.push_back({2'b10, cp[17:12]});
				byte_plan.push_back({2'b10, cp[11:6]});
				byte_plan.push_back({2'b10, cp[5:0]});
			end
		endcase
		known_points.push_back(cp);
		if (known_points.size() > 64)
			void'(known_points.pop_front());
	endfunction

	function automatic bit [CP_W-1:0] pick_point();
		int r;
		r = $urandom_range(99);
		if (r < 40)
			return CP_W'($urandom_range(0, 8'h7F));
		if (r < 65)
			return CP_W'($urandom_range(8'h80, 11'h7FF));
		if (r < 88)
			return CP_W'($urandom_range(12'h800, 16'hFFFF));
		return CP_W'($urandom_range(17'h10000, 21'h1FFFFF));
	endfunction

	function automatic bit [CP_W-1:0] pick_query();
		int r;
		r = $urandom_range(99);
		if (r < 40 && known_points.size() != 0)
			return known_points[$urandom_range(0, known_points.size() - 1)];
		if (r < 60)
			return CP_W'($urandom_range(0, 300));
		if (r < 75)
			return CP_W'($urandom_range(0, 21'h1FFFFF));
		if (r < 85)
			return CP_W'($urandom_range(16'hFFF0, 17'h1000F));
		if (r < 92)
			return CP_REPLACEMENT;
		return '0;
	endfunction

	function automatic bit [GLYPH_W-1:0] pick_glyph_count();
		int r;
		r = $urandom_range(99);
		if (r < 20)
			return GLYPH_W'($urandom_range(1, 8));
		if (r < 55)
			return GLYPH_W'($urandom_range(16, 300));
		if (r < 65)
			return '0;
		if (r < 75)
			return '1;
		return GLYPH_W'($urandom_range(0, 16'hFFFF));
	endfunction

	task automatic send_glyph_entry();
		int n_points;
		int i;
		n_points = $urandom_range(0, 3);
		byte_plan.delete();
		for (i = 0; i < n_points; i++) begin
			encode_point(pick_point());
			if ($urandom_range(9) == 0)
				byte_plan.push_back(BYTE_SKIP);
		end
		byte_plan.push_back(BYTE_END_GLYPH);
		while (byte_plan.size() != 0)
			send_table_byte(byte_plan.pop_front(), $urandom_range(99) < 2);
	endtask

	task automatic send_broken_sequence();
		int len;
		int conts;
		int i;
		case ($urandom_range(3))
			0: send_table_byte(8'($urandom_range(8'h80, 8'hBF)), 1'b0);
			1: send_table_byte(8'($urandom_range(8'hF8, 8'hFD)), 1'b0);
			default: begin
				len = $urandom_range(2, 4);
				if (len == 2)
					send_table_byte({3'b110, 5'($urandom)}, 1'b0);
				else if (len == 3)
					send_table_byte({4'b1110, 4'($urandom)}, 1'b0);
				else
					send_table_byte({5'b11110, 3'($urandom)}, 1'b0);
				conts = $urandom_range(0, len - 2);
				for (i = 0; i < conts; i++)
					send_table_byte({2'b10, 6'($urandom)}, 1'b0);
				if ($urandom_range(1))
					send_table_byte(8'($urandom_range(0, 8'h7F)), 1'b0);
				else
					send_table_byte(8'($urandom_range(8'hC0, 8'hFF)), 1'b0);
			end
		endcase
	endtask

	task automatic test_table_decoding();
		bit [7:0] table_seq [21] = '{BYTE_END_GLYPH, 8'h41, 8'hC3, 8'hA9, BYTE_SKIP,
			BYTE_END_GLYPH, 8'hE2, 8'h82, 8'hAC, 8'h80, BYTE_END_GLYPH, 8'hC3, 8'h42,
			8'hC0, 8'h81, 8'hF0, 8'h90, 8'h80, 8'h80, 8'hF8, 8'hE2};
		bit [CP_W-1:0] probes [11] = '{21'h41, 21'hE9, 21'h20AC, CP_REPLACEMENT, 21'h42,
			21'h01, 21'h43, CP_PLANE_LIMIT, 21'h0, 21'h1FFFFF, 21'h300};
		foreach (table_seq[i])
			send_table_byte(table_seq[i], 1'b0);
		send_table_byte(8'h82, 1'b1);
		send_table_byte(8'h43, 1'b0);
		foreach (probes[i])
			send_lookup(probes[i]);
	endtask

	task automatic test_glyph_limit();
		settle();
		send_clear();
		settle();
		write_reg(REG_GLYPH_COUNT, 16'd2);
		send_table_byte(BYTE_END_GLYPH, 1'b0);
		send_table_byte(8'hC3, 1'b0);
		settle();
		write_reg(REG_GLYPH_COUNT, 16'd1);
		send_table_byte(8'hA9, 1'b0);
		send_table_byte(BYTE_END_GLYPH, 1'b0);
		send_table_byte(8'h41, 1'b0);
		send_lookup(21'hE9);
		send_lookup(21'h41);
	endtask

	task automatic test_direct_index();
		settle();
		write_reg(REG_UNICODE_ENABLED, 16'hFFFE);
		send_lookup(21'hE9);
		settle();
		write_reg(REG_GLYPH_COUNT, 16'hFFFF);
		send_lookup(21'hE9);
		send_lookup(21'hFFFF);
		send_lookup(21'h1FFFFF);
		settle();
		write_reg(REG_GLYPH_COUNT, 16'h0000);
		send_lookup(21'h0);
		send_item(KIND_UNUSED, 8'hFF, 1'b1, 21'h1FFFFF);
		settle();
		write_reg(REG_UNICODE_ENABLED, 16'h0001);
	endtask

	task automatic test_random_tables();
		int phase;
		int goal;
		int sel;
		for (phase = 0; phase < 4; phase++) begin
			steady = (phase == 1);
			settle();
			send_clear();
			settle();
			write_reg(REG_GLYPH_COUNT, pick_glyph_count());
			write_reg(REG_UNICODE_ENABLED, GLYPH_W'($urandom));
			goal = live_items + 125;
			while (live_items < goal) begin
				sel = $urandom_range(99);
				if (table_done && sel < 70)
					sel = 60;
				if (sel < 50) begin
					send_glyph_entry();
				end else if (sel < 75) begin
					send_lookup(pick_query());
				end else if (sel < 87) begin
					send_broken_sequence();
				end else if (sel < 93) begin
					send_table_byte(8'($urandom_range(255)), $urandom_range(99) < 3);
				end else if (sel < 96) begin
					send_item(KIND_UNUSED, 8'($urandom_range(255)), 1'($urandom_range(1)),
						CP_W'($urandom_range(0, 21'h1FFFFF)));
				end else begin
					settle();
					if ($urandom_range(1))
						write_reg(REG_GLYPH_COUNT, pick_glyph_count());
					else
						write_reg(REG_UNICODE_ENABLED, GLYPH_W'($urandom));
				end
			end
		end
		steady = 1'b0;
	endtask

	always @(posedge clk)
		out_ready <= steady || ($urandom_range(99) >= 38);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_glyphs.size() == 0)
				report_mismatch($sformatf("unexpected glyph_number %0h", glyph_number));
			else if (glyph_number !== pending_glyphs[0])
				report_mismatch($sformatf("glyph_number %0h, expected %0h",
					glyph_number, pending_glyphs.pop_front()));
			else
				void'(pending_glyphs.pop_front());
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		kind <= KIND_BYTE;
		table_byte <= '0;
		end_of_table <= 1'b0;
		query_point <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_GLYPH_COUNT;
		cfg_wdata <= '0;
		clear_image();
		glyph_limit = 16'd256;
		map_on = 1'b1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_table_decoding();
		test_glyph_limit();
		test_direct_index();
		test_random_tables();
		settle();

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
